// File: src/oaht_pkg.sv
package oaht_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;

    localparam logic [2:0] REQ_PROBE   = 3'd0;
    localparam logic [2:0] REQ_INSERT  = 3'd1;
    localparam logic [2:0] REQ_REPLACE = 3'd2;
    localparam logic [2:0] REQ_DELETE  = 3'd3;
    localparam logic [2:0] REQ_CLEAR   = 3'd4;

    localparam logic [1:0] SLOT_EMPTY   = 2'd0;
    localparam logic [1:0] SLOT_VALID   = 2'd1;
    localparam logic [1:0] SLOT_DELETED = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic        found;
        logic [31:0] old_value;
        logic        status;
    } t_rsp;

endpackage

// File: src/oaht_req_if.sv
interface oaht_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         req_type;
    logic signed [31:0] key;
    logic [31:0]        hash;
    logic signed [31:0] new_value;

    modport source (output valid, req_type, key, hash, new_value, input ready);
    modport sink   (input valid, req_type, key, hash, new_value, output ready);
endinterface

// File: src/oaht_rsp_if.sv
interface oaht_rsp_if;
    logic               valid;
    logic               ready;
    logic               found;
    logic signed [31:0] old_value;
    logic               status;

    modport source (output valid, found, old_value, status, input ready);
    modport sink   (input valid, found, old_value, status, output ready);
endinterface

// File: src/oaht_front.sv
module oaht_front #(
    parameter int TABLE_DEPTH = oaht_pkg::TABLE_DEPTH_DEF,
    parameter int PW          = $clog2(TABLE_DEPTH),
    parameter int JW          = 67 + 2 * PW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_init_busy,
    oaht_req_if.sink      i_req,
    output logic          o_job_valid,
    input  logic          i_job_ready,
    output logic [JW-1:0] o_job
);
    import oaht_pkg::*;

    // round-up reciprocal for an exact 32-bit divide by the table depth
    localparam logic [63:0] RECIP_WIDE = ((((64'd1 << PW) - 64'(TABLE_DEPTH)) << 32)
                                          / 64'(TABLE_DEPTH)) + 64'd1;
    localparam logic [31:0] RECIP      = RECIP_WIDE[31:0];
    localparam logic [31:0] DIVISOR    = 32'(TABLE_DEPTH);

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_MUL  = 3'd1;
    localparam logic [2:0] F_QUO  = 3'd2;
    localparam logic [2:0] F_REM  = 3'd3;
    localparam logic [2:0] F_PUSH = 3'd4;

    logic [2:0]        r_state, n_state;
    logic              r_pass, n_pass;
    logic [31:0]       r_dvd, n_dvd;
    logic [31:0]       r_t1, n_t1;
    logic [31:0]       r_quo, n_quo;
    logic [PW-1:0]     r_start, n_start;
    logic [PW-1:0]     r_inc, n_inc;
    logic [2:0]        r_req, n_req;
    logic [31:0]       r_key, n_key;
    logic [31:0]       r_val, n_val;
    logic [63:0]       w_prod;
    logic [31:0]       w_quo;
    logic [31:0]       w_qd;
    logic [31:0]       w_diff;

    assign w_prod = 64'(r_dvd) * 64'(RECIP);
    assign w_quo  = (r_t1 + ((r_dvd - r_t1) >> 1)) >> (PW - 1);
    assign w_qd   = r_quo * DIVISOR;
    assign w_diff = r_dvd - w_qd;

    always_comb begin
        n_state = r_state;
        n_pass  = r_pass;
        n_dvd   = r_dvd;
        n_t1    = r_t1;
        n_quo   = r_quo;
        n_start = r_start;
        n_inc   = r_inc;
        n_req   = r_req;
        n_key   = r_key;
        n_val   = r_val;
        case (r_state)
            F_IDLE: begin
                if (i_req.valid && i_req.ready) begin
                    n_req   = i_req.req_type;
                    n_key   = i_req.key;
                    n_val   = i_req.new_value;
                    n_dvd   = i_req.hash;
                    n_pass  = 1'b0;
                    n_start = '0;
                    n_inc   = '0;
                    if (i_req.req_type inside {REQ_PROBE, REQ_INSERT, REQ_REPLACE,
                                               REQ_DELETE}) begin
                        n_state = F_MUL;
                    end else begin
                        n_state = F_PUSH;
                    end
                end
            end
            F_MUL: begin
                n_t1    = w_prod[63:32];
                n_state = F_QUO;
            end
            F_QUO: begin
                n_quo   = w_quo;
                n_state = F_REM;
            end
            F_REM: begin
                if (!r_pass) begin
                    // quotient feeds the second division
                    n_start = w_diff[PW-1:0];
                    n_dvd   = r_quo;
                    n_pass  = 1'b1;
                    n_state = F_MUL;
                end else begin
                    n_inc   = w_diff[PW-1:0] >> 1;
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (i_job_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_pass  <= n_pass;
        r_dvd   <= n_dvd;
        r_t1    <= n_t1;
        r_quo   <= n_quo;
        r_start <= n_start;
        r_inc   <= n_inc;
        r_req   <= n_req;
        r_key   <= n_key;
        r_val   <= n_val;
    end

    assign i_req.ready = (r_state == F_IDLE) && !i_init_busy;
    assign o_job_valid = (r_state == F_PUSH);
    assign o_job       = {r_req, r_key, r_val, r_start, r_inc};

endmodule

// File: src/oaht_fifo.sv
module oaht_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    output logic         o_full_n,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_pop,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wr, r_rd;
    logic [1:0]   r_count;
    logic         w_push, w_pop;

    assign o_full_n = (r_count != 2'd2);
    assign o_valid  = (r_count != 2'd0);
    assign w_push   = i_push && o_full_n;
    assign w_pop    = i_pop && o_valid;
    assign o_data   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) r_wr <= !r_wr;
            if (w_pop) r_rd <= !r_rd;
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) r_mem[r_wr] <= i_data;
    end

endmodule

// File: src/oaht_back.sv
module oaht_back #(
    parameter int TABLE_DEPTH = oaht_pkg::TABLE_DEPTH_DEF,
    parameter int PW          = $clog2(TABLE_DEPTH),
    parameter int LW          = $clog2(TABLE_DEPTH + 1),
    parameter int JW          = 67 + 2 * PW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    output logic          o_job_pop,
    input  logic [JW-1:0] i_job,
    oaht_rsp_if.source    o_rsp,
    output logic          o_init_busy,
    output logic [LW-1:0] o_live
);
    import oaht_pkg::*;

    localparam logic [LW-1:0] LOAD_LIMIT = LW'((TABLE_DEPTH >> 1) + (TABLE_DEPTH >> 2)
                                               + (TABLE_DEPTH >> 3));
    localparam logic [LW-1:0] LAST_STEP  = LW'(TABLE_DEPTH);
    localparam logic [PW:0]   DEPTH_W    = (PW + 1)'(TABLE_DEPTH);
    localparam logic [PW-1:0] LAST_POS   = PW'(TABLE_DEPTH - 1);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_CLEAR = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [65:0]   r_mem [TABLE_DEPTH];
    logic [65:0]   r_rd;
    logic [2:0]    r_state, n_state;
    logic [PW-1:0] r_pos, n_pos;
    logic [PW-1:0] r_spot, n_spot;
    logic          r_have, n_have;
    logic [LW-1:0] r_step, n_step;
    logic [LW-1:0] r_live, n_live;
    logic [2:0]    r_req, n_req;
    logic [31:0]   r_key, n_key;
    logic [31:0]   r_val, n_val;
    logic [PW-1:0] r_inc, n_inc;
    t_rsp          r_res, n_res;
    t_rsp          r_out, n_out;
    logic          r_out_valid, n_out_valid;
    logic          w_we;
    logic [PW-1:0] w_waddr;
    logic [65:0]   w_wdata;
    logic [1:0]    w_st;
    logic [31:0]   w_skey, w_sval;
    logic [PW:0]   w_sum;
    logic [PW-1:0] w_next;

    assign w_st   = r_rd[65:64];
    assign w_skey = r_rd[63:32];
    assign w_sval = r_rd[31:0];

    always_comb begin
        w_sum = {1'b0, r_pos} + (r_step == '0 ? {1'b0, r_inc} : (PW + 1)'(1));
        if (w_sum >= DEPTH_W) w_sum = w_sum - DEPTH_W;
        w_next = w_sum[PW-1:0];
    end

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_spot      = r_spot;
        n_have      = r_have;
        n_step      = r_step;
        n_live      = r_live;
        n_req       = r_req;
        n_key       = r_key;
        n_val       = r_val;
        n_inc       = r_inc;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_job_pop   = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_pos;
        w_wdata     = {SLOT_EMPTY, 64'd0};
        if (o_rsp.ready) n_out_valid = 1'b0;
        case (r_state)
            S_INIT, S_CLEAR: begin
                w_we  = 1'b1;
                n_pos = r_pos + PW'(1);
                if (r_pos == LAST_POS) begin
                    n_pos = '0;
                    if (r_state == S_CLEAR) begin
                        n_live  = '0;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    {n_req, n_key, n_val, n_pos, n_inc} = i_job;
                    n_step = '0;
                    n_have = 1'b0;
                    n_spot = '0;
                    n_res  = '{found: 1'b0, old_value: 32'd0, status: STATUS_OK};
                    if (n_req == REQ_CLEAR) begin
                        n_pos   = '0;
                        n_state = S_CLEAR;
                    end else if (n_req inside {REQ_PROBE, REQ_INSERT, REQ_REPLACE,
                                               REQ_DELETE}) begin
                        n_state = S_EVAL;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_EVAL: begin
                n_state = S_OUT;
                if (w_st == SLOT_EMPTY) begin
                    if (r_req != REQ_DELETE && r_req != REQ_PROBE) begin
                        if (r_live > LOAD_LIMIT) begin
                            n_res.status = STATUS_FULL;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = r_have ? r_spot : r_pos;
                            w_wdata = {SLOT_VALID, r_key, r_val};
                            n_live  = r_live + LW'(1);
                        end
                    end
                end else if (w_st == SLOT_VALID && w_skey == r_key) begin
                    n_res.found     = 1'b1;
                    n_res.old_value = w_sval;
                    if (r_req == REQ_REPLACE) begin
                        w_we    = 1'b1;
                        w_wdata = {SLOT_VALID, r_key, r_val};
                    end else if (r_req == REQ_DELETE) begin
                        w_we    = 1'b1;
                        w_wdata = {SLOT_DELETED, w_skey, w_sval};
                        if (r_live != '0) n_live = r_live - LW'(1);
                    end
                end else begin
                    // remember the first tombstone for a later insert
                    if (w_st != SLOT_VALID && r_req != REQ_DELETE && !r_have) begin
                        n_have = 1'b1;
                        n_spot = r_pos;
                    end
                    if (r_step == LAST_STEP) begin
                        if (r_req == REQ_INSERT || r_req == REQ_REPLACE) begin
                            n_res.status = STATUS_FULL;
                        end
                    end else begin
                        n_pos   = w_next;
                        n_step  = r_step + LW'(1);
                        n_state = S_EVAL;
                    end
                end
            end
            S_OUT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // read data always follows the next probe address
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rd <= r_mem[n_pos];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_pos       <= '0;
            r_live      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_live      <= n_live;
            r_out_valid <= n_out_valid;
        end
        r_spot <= n_spot;
        r_have <= n_have;
        r_step <= n_step;
        r_req  <= n_req;
        r_key  <= n_key;
        r_val  <= n_val;
        r_inc  <= n_inc;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.found     = r_out.found;
    assign o_rsp.old_value = r_out.old_value;
    assign o_rsp.status    = r_out.status;
    assign o_init_busy     = (r_state == S_INIT);
    assign o_live          = r_live;

endmodule

// File: src/open_addressing_hash_table.sv
// Flow: the front end does the hash arithmetic (two reciprocal divides by the depth,
// skipped for clear and unknown requests) and pushes a job into a two-entry queue;
// the back end pops it, probes one slot per step and loads the output register.
// A new request can be taken while the back end still works on earlier jobs;
// a clear writes every slot empty before its response.
// Reset: synchronous, active low; a clearing pass over every slot follows.
module open_addressing_hash_table #(
    parameter int TABLE_DEPTH = oaht_pkg::TABLE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    oaht_req_if.sink   i_req,
    oaht_rsp_if.source o_rsp
);
    import oaht_pkg::*;

    localparam int PW = $clog2(TABLE_DEPTH);
    localparam int LW = $clog2(TABLE_DEPTH + 1);
    localparam int JW = 67 + 2 * PW;

    logic          w_init_busy;
    logic          w_fjob_valid, w_fjob_ready;
    logic [JW-1:0] w_fjob;
    logic          w_bjob_valid, w_bjob_pop;
    logic [JW-1:0] w_bjob;
    logic [LW-1:0] w_live;

    oaht_front #(.TABLE_DEPTH(TABLE_DEPTH), .PW(PW), .JW(JW)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_init_busy (w_init_busy),
        .i_req       (i_req),
        .o_job_valid (w_fjob_valid),
        .i_job_ready (w_fjob_ready),
        .o_job       (w_fjob)
    );

    oaht_fifo #(.W(JW)) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_fjob_valid),
        .o_full_n (w_fjob_ready),
        .i_data   (w_fjob),
        .o_valid  (w_bjob_valid),
        .i_pop    (w_bjob_pop),
        .o_data   (w_bjob)
    );

    oaht_back #(.TABLE_DEPTH(TABLE_DEPTH), .PW(PW), .LW(LW), .JW(JW)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_bjob_valid),
        .o_job_pop   (w_bjob_pop),
        .i_job       (w_bjob),
        .o_rsp       (o_rsp),
        .o_init_busy (w_init_busy),
        .o_live      (w_live)
    );

`ifndef ASSERT_OFF
    a_no_accept_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |-> !w_init_busy)
        else $error("request accepted during clearing pass");

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_live <= LW'(TABLE_DEPTH))
        else $error("live count exceeds table depth");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bjob_pop |-> w_bjob_valid)
        else $error("back end popped an empty queue");
`endif

endmodule

// File: verif/oaht_checker.sv
`timescale 1ns / 1ps

module oaht_checker #(
    parameter int TABLE_DEPTH = oaht_pkg::TABLE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    oaht_req_if  i_req,
    oaht_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_hits,
    output int   o_refused,
    output int   o_replies
);
    import oaht_pkg::*;

    localparam int unsigned LOAD_LIMIT = (TABLE_DEPTH >> 1) + (TABLE_DEPTH >> 2)
                                       + (TABLE_DEPTH >> 3);

    logic [1:0]  slot_state [TABLE_DEPTH];
    logic [31:0] slot_key   [TABLE_DEPTH];
    logic [31:0] slot_val   [TABLE_DEPTH];
    int unsigned live_slots;
    t_rsp        expected_rsp_q [$];

    function automatic int unsigned next_pos(int unsigned pos, int step, logic [31:0] h);
        if (step == 0)
            return (pos + (((h / TABLE_DEPTH) % TABLE_DEPTH) >> 1)) % TABLE_DEPTH;
        return (pos + 1) % TABLE_DEPTH;
    endfunction

    function automatic t_rsp table_access(logic [2:0] rq, logic [31:0] k, logic [31:0] h,
                                          logic [31:0] v);
        t_rsp        r;
        int unsigned pos;
        int unsigned spot;
        bit          have_spot;
        bit          done;
        r = '0;
        pos = h % TABLE_DEPTH;
        have_spot = 0;
        done = 0;
        spot = 0;
        if (rq == REQ_PROBE || rq == REQ_INSERT || rq == REQ_REPLACE) begin
            for (int i = 0; i <= TABLE_DEPTH && !done; i++) begin
                if (slot_state[pos] == SLOT_EMPTY) begin
                    done = 1;
                    if (live_slots > LOAD_LIMIT) begin
                        if (rq != REQ_PROBE) r.status = STATUS_FULL;
                    end else if (rq != REQ_PROBE) begin
                        // reuse the first tombstone on the chain
                        if (!have_spot) spot = pos;
                        slot_key[spot]   = k;
                        slot_val[spot]   = v;
                        slot_state[spot] = SLOT_VALID;
                        live_slots++;
                    end
                end else if (slot_state[pos] == SLOT_VALID && slot_key[pos] == k) begin
                    done = 1;
                    r.found = 1'b1;
                    r.old_value = slot_val[pos];
                    if (rq == REQ_REPLACE) slot_val[pos] = v;
                end else if (slot_state[pos] != SLOT_VALID && !have_spot) begin
                    have_spot = 1;
                    spot = pos;
                end
                if (!done) pos = next_pos(pos, i, h);
            end
            if (!done && rq != REQ_PROBE) r.status = STATUS_FULL;
        end else if (rq == REQ_DELETE) begin
            for (int i = 0; i <= TABLE_DEPTH && !done; i++) begin
                if (slot_state[pos] == SLOT_EMPTY) begin
                    done = 1;
                end else if (slot_state[pos] == SLOT_VALID && slot_key[pos] == k) begin
                    done = 1;
                    slot_state[pos] = SLOT_DELETED;
                    if (live_slots > 0) live_slots--;
                    r.found = 1'b1;
                    r.old_value = slot_val[pos];
                end else begin
                    pos = next_pos(pos, i, h);
                end
            end
        end else if (rq == REQ_CLEAR) begin
            foreach (slot_state[j]) slot_state[j] = SLOT_EMPTY;
            live_slots = 0;
        end
        return r;
    endfunction

    initial begin
        foreach (slot_state[j]) slot_state[j] = SLOT_EMPTY;
        live_slots = 0;
        o_fail_count = 0;
        o_pending = 0;
        o_hits = 0;
        o_refused = 0;
        o_replies = 0;
    end

    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n) begin
            if (i_req.valid && i_req.ready)
                expected_rsp_q.push_back(table_access(i_req.req_type, i_req.key,
                                                      i_req.hash, i_req.new_value));
            if (i_rsp.valid && i_rsp.ready) begin
                o_replies <= o_replies + 1;
                if (expected_rsp_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: unexpected response found=%0b old=%h status=%0b",
                                 $time, i_rsp.found, i_rsp.old_value, i_rsp.status);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_rsp = expected_rsp_q.pop_front();
                    if (exp_rsp.found) o_hits <= o_hits + 1;
                    if (exp_rsp.status == STATUS_FULL) o_refused <= o_refused + 1;
                    if (i_rsp.found !== exp_rsp.found || i_rsp.status !== exp_rsp.status ||
                        i_rsp.old_value !== exp_rsp.old_value) begin
                        if (o_fail_count < 10)
                            $display({"%0t: mismatch exp found=%0b old=%h status=%0b,",
                                      " got found=%0b old=%h status=%0b"},
                                     $time, exp_rsp.found, exp_rsp.old_value, exp_rsp.status,
                                     i_rsp.found, i_rsp.old_value, i_rsp.status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= expected_rsp_q.size();
        end
    end

endmodule

// File: verif/open_addressing_hash_table_tb.sv
`timescale 1ns / 1ps

module open_addressing_hash_table_tb;
    import oaht_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   hits;
    int   refused;
    int   replies;
    bit   long_hold;
    int   sent;
    int   next_key;

    oaht_req_if req_ch ();
    oaht_rsp_if rsp_ch ();

    open_addressing_hash_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    oaht_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_hits       (hits),
        .o_refused    (refused),
        .o_replies    (replies)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #100ms;
        $display("timeout with %0d responses still expected", pending);
        $display("** open_addressing_hash_table: FAILED **");
        $finish;
    end

    function automatic logic [31:0] mix_hash(logic [31:0] k);
        return (k * 32'h9E37_79B1) ^ (k >> 13) ^ 32'h5A5A_0000;
    endfunction

    // drive one request; hold valid until the transfer
    task automatic send(logic [2:0] rq, logic [31:0] k, logic [31:0] h, logic [31:0] v);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= rq;
        req_ch.key       <= k;
        req_ch.hash      <= h;
        req_ch.new_value <= v;
        do @(posedge i_clk); while (!req_ch.ready);
        sent++;
    endtask

    task automatic send_keyed(logic [2:0] rq, logic [31:0] k);
        logic [31:0] h;
        h = ($urandom_range(0, 9) == 0) ? $urandom() : mix_hash(k);
        send(rq, k, h, $urandom());
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [2:0] pick_op(int ins_weight);
        int r;
        r = $urandom_range(0, 99);
        if (r < ins_weight) return REQ_INSERT;
        if (r < ins_weight + 15) return REQ_REPLACE;
        if (r < ins_weight + 30) return REQ_PROBE;
        if (r < ins_weight + 45) return REQ_DELETE;
        if (r < ins_weight + 47) return REQ_CLEAR;
        return 3'd5 + 3'($urandom_range(0, 2));
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int wait_n;
        rsp_ch.ready <= 1'b0;
        forever begin
            if (long_hold) begin
                rsp_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                long_hold = 0;
            end
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            if (wait_n > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
        end
    end

    initial begin
        logic [31:0] key_pool [48];
        logic [31:0] k;
        logic [2:0]  op;
        sent = 0;
        long_hold = 0;
        next_key = 32'h1000;
        i_rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.req_type <= REQ_PROBE;
        req_ch.key <= '0;
        req_ch.hash <= '0;
        req_ch.new_value <= '0;
        foreach (key_pool[j]) key_pool[j] = $urandom();
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every request, tombstone reuse, first-step offset
        send(REQ_PROBE,   32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
        send(REQ_INSERT,  32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
        send(REQ_INSERT,  32'h8000_0000, 32'h0000_0000, 32'h1234_5678);
        send(REQ_REPLACE, 32'h8000_0000, 32'h0000_0000, 32'h8000_0000);
        send(REQ_PROBE,   32'h8000_0000, 32'h0000_0000, 32'h0);
        send(REQ_REPLACE, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(REQ_INSERT,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
        send(REQ_INSERT,  32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0002);
        send(REQ_PROBE,   32'h0000_0000, 32'hFFFF_FFFF, 32'h0);
        send(REQ_DELETE,  32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        send(REQ_DELETE,  32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        send(REQ_INSERT,  32'h0000_0005, 32'hFFFF_FFFF, 32'hAAAA_5555);
        send(REQ_PROBE,   32'h0000_0000, 32'hFFFF_FFFF, 32'h0);
        send(3'd5,        32'h0000_0005, 32'hFFFF_FFFF, 32'h0);
        send(3'd6,        32'h0,         32'h0,         32'h0);
        send(3'd7,        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(REQ_DELETE,  32'h0000_0123, 32'h0000_0400, 32'h0);
        send(REQ_CLEAR,   32'h0,         32'h0,         32'h0);
        send(REQ_PROBE,   32'h8000_0000, 32'h0000_0000, 32'h0);
        send(REQ_INSERT,  32'h5555_AAAA, 32'hAAAA_5555, 32'h5555_AAAA);

        // mixed traffic on a small key set
        for (int n = 0; n < 300; n++) begin
            op = pick_op(25);
            send_keyed(op, key_pool[$urandom_range(0, 47)]);
        end

        // pause until idle, then stall the receiver while the table fills
        drain();
        send(REQ_CLEAR, 32'h0, 32'h0, 32'h0);
        long_hold = 1;
        for (int n = 0; n < 850; n++) begin
            op = pick_op(80);
            if (op == REQ_CLEAR) op = REQ_INSERT;
            if (op == REQ_INSERT) begin
                next_key++;
                k = mix_hash(next_key) ^ 32'hC3C3_3C3C;
            end else begin
                k = mix_hash($urandom_range(32'h1001, next_key)) ^ 32'hC3C3_3C3C;
            end
            send_keyed(op, k);
        end

        // more mixed traffic on the loaded table, half on new keys; lookups still walk long chains
        for (int n = 0; n < 80; n++) begin
            op = pick_op(40);
            if (op == REQ_CLEAR) op = REQ_PROBE;
            next_key++;
            k = ($urandom_range(0, 1) == 0) ? mix_hash(next_key) ^ 32'hC3C3_3C3C :
                mix_hash($urandom_range(32'h1001, next_key)) ^ 32'hC3C3_3C3C;
            send_keyed(op, k);
        end

        drain();
        repeat (1100) @(posedge i_clk);
        $display("%0d requests sent, %0d responses: %0d hits, %0d inserts refused as full",
                 sent, replies, hits, refused);
        if (fail_count == 0 && pending == 0) begin
            $display("** open_addressing_hash_table: PASSED **");
        end else begin
            $display("%0d mismatches, %0d responses missing", fail_count, pending);
            $display("** open_addressing_hash_table: FAILED **");
        end
        $finish;
    end

endmodule
